>>> rtl/carpi_pkg.sv
// ----------------------------------------------------------------------------
// carpi_pkg: shared definitions for the cascaded attitude/rate PI controller
// Register indices, loop constants, sequencer codes and saturation helpers.
// ----------------------------------------------------------------------------
package carpi_pkg;

  localparam int DATA_W    = 32;
  localparam int REG_COUNT = 8;
  localparam int IDX_W     = 4;

  // Integrator step divisors: 1/dt for the 250 Hz and 500 Hz loops.
  localparam int ATT_DT_DIV  = 250;
  localparam int RATE_DT_DIV = 500;
  localparam int DIV_W       = 9;

  // Q16.16 product magnitude is below 2^63; the fraction drops 16 bits.
  localparam int FRAC_W  = 16;
  localparam int QUO_W   = 47;
  localparam int DIGIT_W = 4;
  localparam int MUL_STEPS = DATA_W / DIGIT_W;
  localparam int CNT_W     = 6;

  typedef enum logic [2:0] {
    REG_ATT_KP_ROLL  = 3'd0,
    REG_ATT_KP_PITCH = 3'd1,
    REG_ATT_KI_ROLL  = 3'd2,
    REG_ATT_KI_PITCH = 3'd3,
    REG_RATE_KP_ROLL = 3'd4,
    REG_RATE_KP_PITCH = 3'd5,
    REG_RATE_KP_YAW  = 3'd6,
    REG_RATE_KI_YAW  = 3'd7
  } reg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_ACC  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  // One multiply-accumulate each; the order is the evaluation order.
  typedef enum logic [2:0] {
    OP_ROLL_I  = 3'd0,
    OP_ROLL_P  = 3'd1,
    OP_PITCH_I = 3'd2,
    OP_PITCH_P = 3'd3,
    OP_YAW_I   = 3'd4,
    OP_ROLL_D  = 3'd5,
    OP_PITCH_D = 3'd6,
    OP_YAW_D   = 3'd7
  } op_t;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -49'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

>>> rtl/cascaded_attitude_rate_pi_top.sv
// ----------------------------------------------------------------------------
// cascaded_attitude_rate_pi_top: cascaded attitude PI / rate PI controller
// Q16.16 outer attitude loop on alternate ticks and inner rate loop on every
// tick, evaluated on one shared digit-serial multiplier and divider.
// ----------------------------------------------------------------------------
//  Channel   Signals                               Direction  Width
//  input     in_valid/in_ready + 8 measured fields in         32 each
//  output    out_valid/out_ready + 3 drive fields  out        32 each
//  config    cfg_write, cfg_index, cfg_data        in         1/4/32
//
// Each request runs a list of multiply-accumulates on one radix-16 multiplier
// and, for integrator steps, a one-bit-per-cycle divider by the loop rate. A
// new request is taken only once the previous one has moved to the output
// register, which then holds it while out_ready is low. Reset clears gains,
// integrators, targets and the outer loop phase.
module cascaded_attitude_rate_pi_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] roll_rate,
  input  logic signed [31:0] pitch_rate,
  input  logic signed [31:0] yaw_rate,
  input  logic signed [31:0] roll_angle,
  input  logic signed [31:0] pitch_angle,
  input  logic signed [31:0] roll_command,
  input  logic signed [31:0] pitch_command,
  input  logic signed [31:0] yaw_rate_command,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] roll_drive,
  output logic signed [31:0] pitch_drive,
  output logic signed [31:0] yaw_drive
);

  logic signed [31:0] gain_reg [carpi_pkg::REG_COUNT];

  logic signed [31:0] hold_roll_rate;
  logic signed [31:0] hold_pitch_rate;
  logic signed [31:0] hold_yaw_rate;
  logic signed [31:0] hold_roll_angle;
  logic signed [31:0] hold_pitch_angle;
  logic signed [31:0] hold_roll_command;
  logic signed [31:0] hold_pitch_command;
  logic signed [31:0] hold_yaw_rate_command;

  logic               outer_loop_due;
  logic signed [31:0] roll_rate_target;
  logic signed [31:0] pitch_rate_target;
  logic signed [31:0] roll_angle_integral;
  logic signed [31:0] pitch_angle_integral;
  logic signed [31:0] yaw_rate_integral;

  carpi_pkg::state_t state;
  carpi_pkg::op_t    op;
  logic [63:0]       prod;
  logic [63:0]       prod_next;
  logic [31:0]       mcand;
  logic              neg;
  logic [carpi_pkg::CNT_W-1:0] cnt;
  logic [carpi_pkg::QUO_W-1:0] quo;
  logic [carpi_pkg::DIV_W-1:0] rem;

  logic signed [31:0] drive_roll;
  logic signed [31:0] drive_pitch;
  logic signed [31:0] drive_yaw;

  // Operand selection for the current operation.
  logic signed [31:0] gain_sel;
  logic signed [31:0] err_a;
  logic signed [31:0] err_b;
  logic signed [32:0] err_diff;
  logic signed [31:0] err;
  logic signed [31:0] addend;
  logic               use_div;
  logic [carpi_pkg::DIV_W-1:0] divisor;

  logic [35:0]        mul_sum;
  logic [carpi_pkg::DIV_W:0] trial;
  logic               trial_ge;
  logic signed [47:0] term;
  logic signed [48:0] acc_sum;
  logic signed [31:0] acc_res;

  logic in_accept;
  logic out_load;

  assign in_ready  = (state == carpi_pkg::S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_load  = (state == carpi_pkg::S_DONE) && (!out_valid || out_ready);

  always_comb begin
    gain_sel = gain_reg[carpi_pkg::REG_RATE_KP_YAW];
    err_a    = hold_yaw_rate_command;
    err_b    = hold_yaw_rate;
    addend   = '0;
    use_div  = 1'b0;
    divisor  = carpi_pkg::DIV_W'(carpi_pkg::RATE_DT_DIV);
    case (op)
      carpi_pkg::OP_ROLL_I: begin
        gain_sel = gain_reg[carpi_pkg::REG_ATT_KI_ROLL];
        err_a    = hold_roll_command;
        err_b    = hold_roll_angle;
        addend   = roll_angle_integral;
        use_div  = 1'b1;
        divisor  = carpi_pkg::DIV_W'(carpi_pkg::ATT_DT_DIV);
      end
      carpi_pkg::OP_ROLL_P: begin
        gain_sel = gain_reg[carpi_pkg::REG_ATT_KP_ROLL];
        err_a    = hold_roll_command;
        err_b    = hold_roll_angle;
        addend   = roll_angle_integral;
      end
      carpi_pkg::OP_PITCH_I: begin
        gain_sel = gain_reg[carpi_pkg::REG_ATT_KI_PITCH];
        err_a    = hold_pitch_command;
        err_b    = hold_pitch_angle;
        addend   = pitch_angle_integral;
        use_div  = 1'b1;
        divisor  = carpi_pkg::DIV_W'(carpi_pkg::ATT_DT_DIV);
      end
      carpi_pkg::OP_PITCH_P: begin
        gain_sel = gain_reg[carpi_pkg::REG_ATT_KP_PITCH];
        err_a    = hold_pitch_command;
        err_b    = hold_pitch_angle;
        addend   = pitch_angle_integral;
      end
      carpi_pkg::OP_YAW_I: begin
        gain_sel = gain_reg[carpi_pkg::REG_RATE_KI_YAW];
        addend   = yaw_rate_integral;
        use_div  = 1'b1;
        divisor  = carpi_pkg::DIV_W'(carpi_pkg::RATE_DT_DIV);
      end
      carpi_pkg::OP_ROLL_D: begin
        gain_sel = gain_reg[carpi_pkg::REG_RATE_KP_ROLL];
        err_a    = roll_rate_target;
        err_b    = hold_roll_rate;
      end
      carpi_pkg::OP_PITCH_D: begin
        gain_sel = gain_reg[carpi_pkg::REG_RATE_KP_PITCH];
        err_a    = pitch_rate_target;
        err_b    = hold_pitch_rate;
      end
      carpi_pkg::OP_YAW_D: begin
        addend   = yaw_rate_integral;
      end
      default: begin
        addend   = '0;
      end
    endcase
  end

  always_comb begin
    err_diff  = {err_a[31], err_a} - {err_b[31], err_b};
    err       = carpi_pkg::sat32({{16{err_diff[32]}}, err_diff});

    // One radix-16 digit of the multiplier per cycle, product shifts right.
    mul_sum   = {4'b0, prod[63:32]} + 36'(mcand) * 36'(prod[carpi_pkg::DIGIT_W-1:0]);
    prod_next = {mul_sum, prod[31:carpi_pkg::DIGIT_W]};

    trial     = {rem, quo[carpi_pkg::QUO_W-1]};
    trial_ge  = (trial >= {1'b0, divisor});

    term      = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    acc_sum   = {{17{addend[31]}}, addend} + {term[47], term};
    acc_res   = carpi_pkg::sat32(acc_sum);
  end

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < carpi_pkg::REG_COUNT; i++) begin
        gain_reg[i] <= '0;
      end
    end else if (cfg_write && (cfg_index < carpi_pkg::IDX_W'(carpi_pkg::REG_COUNT))) begin
      gain_reg[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_roll_rate        <= roll_rate;
      hold_pitch_rate       <= pitch_rate;
      hold_yaw_rate         <= yaw_rate;
      hold_roll_angle       <= roll_angle;
      hold_pitch_angle      <= pitch_angle;
      hold_roll_command     <= roll_command;
      hold_pitch_command    <= pitch_command;
      hold_yaw_rate_command <= yaw_rate_command;
    end
    if (out_load) begin
      roll_drive  <= drive_roll;
      pitch_drive <= drive_pitch;
      yaw_drive   <= drive_yaw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= carpi_pkg::S_IDLE;
      op                   <= carpi_pkg::OP_ROLL_I;
      outer_loop_due       <= 1'b0;
      roll_rate_target     <= '0;
      pitch_rate_target    <= '0;
      roll_angle_integral  <= '0;
      pitch_angle_integral <= '0;
      yaw_rate_integral    <= '0;
      out_valid            <= 1'b0;
      cnt                  <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        carpi_pkg::S_IDLE: begin
          if (in_accept) begin
            outer_loop_due <= !outer_loop_due;
            op    <= outer_loop_due ? carpi_pkg::OP_ROLL_I : carpi_pkg::OP_YAW_I;
            state <= carpi_pkg::S_LOAD;
          end
        end
        carpi_pkg::S_LOAD: begin
          mcand <= carpi_pkg::mag32(gain_sel);
          prod  <= {32'b0, carpi_pkg::mag32(err)};
          neg   <= gain_sel[31] ^ err[31];
          cnt   <= '0;
          state <= carpi_pkg::S_MUL;
        end
        carpi_pkg::S_MUL: begin
          prod <= prod_next;
          if (cnt == carpi_pkg::CNT_W'(carpi_pkg::MUL_STEPS - 1)) begin
            quo   <= prod_next[carpi_pkg::FRAC_W+carpi_pkg::QUO_W-1:carpi_pkg::FRAC_W];
            rem   <= '0;
            cnt   <= '0;
            state <= use_div ? carpi_pkg::S_DIV : carpi_pkg::S_ACC;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        carpi_pkg::S_DIV: begin
          // Restoring division, one quotient bit per cycle; the remainder
          // always stays below the divisor.
          rem <= trial_ge ? carpi_pkg::DIV_W'(trial - {1'b0, divisor})
                          : trial[carpi_pkg::DIV_W-1:0];
          quo <= {quo[carpi_pkg::QUO_W-2:0], trial_ge};
          cnt <= cnt + 1'b1;
          if (cnt == carpi_pkg::CNT_W'(carpi_pkg::QUO_W - 1)) begin
            state <= carpi_pkg::S_ACC;
          end
        end
        carpi_pkg::S_ACC: begin
          case (op)
            carpi_pkg::OP_ROLL_I:  roll_angle_integral  <= acc_res;
            carpi_pkg::OP_ROLL_P:  roll_rate_target     <= acc_res;
            carpi_pkg::OP_PITCH_I: pitch_angle_integral <= acc_res;
            carpi_pkg::OP_PITCH_P: pitch_rate_target    <= acc_res;
            carpi_pkg::OP_YAW_I:   yaw_rate_integral    <= acc_res;
            carpi_pkg::OP_ROLL_D:  drive_roll           <= acc_res;
            carpi_pkg::OP_PITCH_D: drive_pitch          <= acc_res;
            carpi_pkg::OP_YAW_D:   drive_yaw            <= acc_res;
            default:               drive_yaw            <= acc_res;
          endcase
          if (op == carpi_pkg::OP_YAW_D) begin
            state <= carpi_pkg::S_DONE;
          end else begin
            op    <= carpi_pkg::op_t'(op + 3'd1);
            state <= carpi_pkg::S_LOAD;
          end
        end
        carpi_pkg::S_DONE: begin
          if (out_load) begin
            state <= carpi_pkg::S_IDLE;
          end
        end
        default: begin
          state <= carpi_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/carpi_checker.sv
// ----------------------------------------------------------------------------
// carpi_checker: port-level checks for the attitude/rate controller
// Watches the request channels of the top level over time.
// ----------------------------------------------------------------------------
module carpi_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] roll_drive,
  input logic [31:0] pitch_drive,
  input logic [31:0] yaw_drive
);

  // Nothing is presented straight after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // Requests are processed one at a time, so the input closes after a request.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after a request was taken");

  // A result appears only as the block returns to waiting for input.
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> in_ready)
    else $error("result presented while the block is busy");

  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before it was taken");

  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |=>
      ($stable(roll_drive) && $stable(pitch_drive) && $stable(yaw_drive)))
    else $error("result changed while stalled");

endmodule

bind cascaded_attitude_rate_pi_top carpi_checker u_carpi_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .roll_drive  (roll_drive),
  .pitch_drive (pitch_drive),
  .yaw_drive   (yaw_drive)
);

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: cascaded attitude/rate PI controller testbench
// Sends rate-loop ticks through the request handshake while both sides idle
// and stall at random. The testbench keeps its own Q16.16 copy of the gains,
// the integrators, the held rate targets and the outer loop phase, and it
// compares every drive triple with the oldest expectation.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 2;
  localparam int IDLE_PERCENT    = 31;
  localparam int LONG_GAP_MIN    = 20;
  localparam int LONG_GAP_MAX    = 250;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int SETTLE          = 4;
  localparam int END_SETTLE      = 250;
  localparam int MAX_REPORTED    = 10;
  localparam int CYCLE_LIMIT     = 3000000;
  localparam int TICK_FIELDS     = 8;
  localparam int SMALL_FIELD     = 1 << 18;
  localparam int SMALL_GAIN      = 1 << 20;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam longint WIDE_MAX  = 64'sd2147483647;
  localparam longint WIDE_MIN  = -64'sd2147483648;
  localparam longint ONE_W     = 64'sd1 << carpi_pkg::FRAC_W;
  localparam longint OUTER_DIV = carpi_pkg::ATT_DT_DIV * ONE_W;
  localparam longint YAW_DIV   = carpi_pkg::RATE_DT_DIV * ONE_W;

  typedef enum {RANGE_SMALL, RANGE_FULL, RANGE_EDGE} value_range_t;

  typedef struct packed {
    logic signed [31:0] roll_rate;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] yaw_rate;
    logic signed [31:0] roll_angle;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] roll_command;
    logic signed [31:0] pitch_command;
    logic signed [31:0] yaw_rate_command;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
  } drive_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [carpi_pkg::IDX_W-1:0] cfg_index = '0;
  logic [carpi_pkg::DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] roll_rate = '0;
  logic signed [31:0] pitch_rate = '0;
  logic signed [31:0] yaw_rate = '0;
  logic signed [31:0] roll_angle = '0;
  logic signed [31:0] pitch_angle = '0;
  logic signed [31:0] roll_command = '0;
  logic signed [31:0] pitch_command = '0;
  logic signed [31:0] yaw_rate_command = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] roll_drive;
  logic signed [31:0] pitch_drive;
  logic signed [31:0] yaw_drive;

  // Controller state as the block should hold it.
  logic signed [31:0] gain [carpi_pkg::REG_COUNT] = '{default: '0};
  logic outer_due = 1'b0;
  logic signed [31:0] roll_target = '0;
  logic signed [31:0] pitch_target = '0;
  logic signed [31:0] roll_integ = '0;
  logic signed [31:0] pitch_integ = '0;
  logic signed [31:0] yaw_integ = '0;

  drive_t expected_drives [$];
  int mismatch_count = 0;
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  bit offering = 1'b0;

  cascaded_attitude_rate_pi_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .roll_rate        (roll_rate),
    .pitch_rate       (pitch_rate),
    .yaw_rate         (yaw_rate),
    .roll_angle       (roll_angle),
    .pitch_angle      (pitch_angle),
    .roll_command     (roll_command),
    .pitch_command    (pitch_command),
    .yaw_rate_command (yaw_rate_command),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .roll_drive       (roll_drive),
    .pitch_drive      (pitch_drive),
    .yaw_drive        (yaw_drive)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  function automatic longint wide(input logic signed [31:0] v);
    return longint'(v);
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > WIDE_MAX) begin
      return Q_MAX;
    end else if (v < WIDE_MIN) begin
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  // Full 64-bit product; SystemVerilog division truncates toward zero.
  function automatic longint prop_term(input logic signed [31:0] g, e);
    return wide(g) * wide(e) / ONE_W;
  endfunction

  function automatic logic signed [31:0] integrate_step(
    input logic signed [31:0] acc, g, e, input longint div);
    return clip32(wide(acc) + wide(g) * wide(e) / div);
  endfunction

  // Advances the controller state by one tick and returns its drives.
  function automatic drive_t next_drive(input tick_t t);
    drive_t d;
    logic signed [31:0] e_roll, e_pitch, e_p, e_q, e_r;
    if (outer_due) begin
      e_roll  = clip32(wide(t.roll_command) - wide(t.roll_angle));
      e_pitch = clip32(wide(t.pitch_command) - wide(t.pitch_angle));
      roll_integ = integrate_step(roll_integ, gain[carpi_pkg::REG_ATT_KI_ROLL], e_roll,
                                  OUTER_DIV);
      roll_target = clip32(prop_term(gain[carpi_pkg::REG_ATT_KP_ROLL], e_roll)
                           + wide(roll_integ));
      pitch_integ = integrate_step(pitch_integ, gain[carpi_pkg::REG_ATT_KI_PITCH], e_pitch,
                                   OUTER_DIV);
      pitch_target = clip32(prop_term(gain[carpi_pkg::REG_ATT_KP_PITCH], e_pitch)
                            + wide(pitch_integ));
      outer_due = 1'b0;
    end else begin
      outer_due = 1'b1;
    end
    e_p = clip32(wide(roll_target) - wide(t.roll_rate));
    e_q = clip32(wide(pitch_target) - wide(t.pitch_rate));
    e_r = clip32(wide(t.yaw_rate_command) - wide(t.yaw_rate));
    yaw_integ = integrate_step(yaw_integ, gain[carpi_pkg::REG_RATE_KI_YAW], e_r, YAW_DIV);
    d.roll  = clip32(prop_term(gain[carpi_pkg::REG_RATE_KP_ROLL], e_p));
    d.pitch = clip32(prop_term(gain[carpi_pkg::REG_RATE_KP_PITCH], e_q));
    d.yaw   = clip32(prop_term(gain[carpi_pkg::REG_RATE_KP_YAW], e_r) + wide(yaw_integ));
    return d;
  endfunction

  function automatic value_range_t pick_range(input int small_percent);
    int r;
    r = $urandom_range(99);
    if (r < small_percent) begin
      return RANGE_SMALL;
    end else if (r % 3 != 0) begin
      return RANGE_FULL;
    end
    return RANGE_EDGE;
  endfunction

  function automatic logic signed [31:0] rand_q(input value_range_t range, input int span);
    logic signed [31:0] v;
    case (range)
      RANGE_SMALL: v = $urandom_range(2 * span) - span;
      RANGE_FULL:  v = $urandom;
      default: begin
        case ($urandom_range(4))
          0:       v = Q_MAX;
          1:       v = Q_MIN;
          2:       v = '0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
    endcase
    return v;
  endfunction

  // Mostly flight-like small values, with full-range words and limits mixed in.
  function automatic tick_t rand_tick();
    tick_t t;
    for (int f = 0; f < TICK_FIELDS; f++) begin
      t[f*carpi_pkg::DATA_W +: carpi_pkg::DATA_W] = rand_q(pick_range(70), SMALL_FIELD);
    end
    return t;
  endfunction

  // Commands at one limit and measurements at the other, so the attitude and yaw rate errors clip.
  function automatic tick_t limit_tick(input bit flip);
    tick_t t;
    t.roll_command     = flip ? Q_MIN : Q_MAX;
    t.pitch_command    = flip ? Q_MIN : Q_MAX;
    t.yaw_rate_command = flip ? Q_MIN : Q_MAX;
    t.roll_angle       = flip ? Q_MAX : Q_MIN;
    t.pitch_angle      = flip ? Q_MAX : Q_MIN;
    t.roll_rate        = flip ? Q_MAX : Q_MIN;
    t.pitch_rate       = flip ? Q_MAX : Q_MIN;
    t.yaw_rate         = flip ? Q_MAX : Q_MIN;
    return t;
  endfunction

  task automatic write_reg(input logic [carpi_pkg::IDX_W-1:0] idx,
                           input logic signed [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx < carpi_pkg::REG_COUNT) begin
      gain[idx[2:0]] = value;
    end
  endtask

  task automatic set_all_gains(input logic signed [31:0] value);
    for (int r = 0; r < carpi_pkg::REG_COUNT; r++) begin
      write_reg(carpi_pkg::IDX_W'(r), value);
    end
  endtask

  task automatic set_random_gains(input int small_percent);
    for (int r = 0; r < carpi_pkg::REG_COUNT; r++) begin
      write_reg(carpi_pkg::IDX_W'(r), rand_q(pick_range(small_percent), SMALL_GAIN));
    end
  endtask

  // Offers one tick and records its expected drives once the request is taken.
  task automatic send_tick(input tick_t t);
    int gap;
    if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      gap = ($urandom_range(19) == 0) ? $urandom_range(LONG_GAP_MIN, LONG_GAP_MAX)
                                      : $urandom_range(1, 3);
      if (offering) begin
        in_valid <= 1'b0;
      end
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    roll_rate        <= t.roll_rate;
    pitch_rate       <= t.pitch_rate;
    yaw_rate         <= t.yaw_rate;
    roll_angle       <= t.roll_angle;
    pitch_angle      <= t.pitch_angle;
    roll_command     <= t.roll_command;
    pitch_command    <= t.pitch_command;
    yaw_rate_command <= t.yaw_rate_command;
    offering = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_drives.push_back(next_drive(t));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_tick(rand_tick());
  endtask

  task automatic await_all_drives();
    if (offering) begin
      in_valid <= 1'b0;
    end
    offering = 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Gains are still at their reset value of zero, so every drive is zero.
  task automatic test_reset_state();
    send_random(2);
  endtask

  // Unity gains, and integral gains that make each step equal the error,
  // show which ticks refresh the rate targets.
  task automatic test_outer_cadence();
    await_all_drives();
    set_all_gains(Q_ONE);
    write_reg(carpi_pkg::IDX_W'(carpi_pkg::REG_ATT_KI_ROLL),
              carpi_pkg::ATT_DT_DIV << carpi_pkg::FRAC_W);
    write_reg(carpi_pkg::IDX_W'(carpi_pkg::REG_ATT_KI_PITCH),
              carpi_pkg::ATT_DT_DIV << carpi_pkg::FRAC_W);
    write_reg(carpi_pkg::IDX_W'(carpi_pkg::REG_RATE_KI_YAW),
              carpi_pkg::RATE_DT_DIV << carpi_pkg::FRAC_W);
    repeat (4) send_tick(rand_tick());
  endtask

  task automatic test_unknown_index();
    await_all_drives();
    for (int i = carpi_pkg::REG_COUNT; i < (1 << carpi_pkg::IDX_W); i++) begin
      write_reg(carpi_pkg::IDX_W'(i), $urandom);
    end
    send_random(2);
  endtask

  task automatic test_saturation();
    logic signed [31:0] limits [5];
    limits = '{Q_MAX, Q_MIN, 0, -1, 1};
    await_all_drives();
    set_all_gains(Q_MAX);
    send_tick(limit_tick(1'b0));
    send_tick(limit_tick(1'b1));
    foreach (limits[i]) send_tick({TICK_FIELDS{limits[i]}});
    await_all_drives();
    set_all_gains(Q_MIN);
    send_tick(limit_tick(1'b0));
    send_tick(limit_tick(1'b1));
    send_tick({TICK_FIELDS{Q_MAX}});
    send_tick({TICK_FIELDS{Q_MIN}});
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 5; phase++) begin
      await_all_drives();
      set_random_gains(80);
      send_random(110);
    end
    await_all_drives();
    set_all_gains(Q_MAX);
    send_random(50);
    await_all_drives();
    set_all_gains(Q_MIN);
    send_random(50);
  endtask

  // The sink refuses results long enough for the block to fill and stall.
  task automatic test_backpressure();
    await_all_drives();
    set_random_gains(90);
    hold_off_req = 1'b1;
    send_random(40);
  endtask

  task automatic test_sender_pause();
    send_random(40);
    await_all_drives();
    send_random(40);
  endtask

  task automatic test_no_idling();
    calm = 1'b1;
    send_random(80);
    calm = 1'b0;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want, got);
    if (got !== want) begin
      if (mismatch_count < MAX_REPORTED) begin
        $display("%0t: %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                 $time, name, want, want, got, got);
      end
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : drive_checker
    drive_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_drives.size() == 0) begin
        if (mismatch_count < MAX_REPORTED) begin
          $display("%0t: result with no request outstanding", $time);
        end
        mismatch_count++;
      end else begin
        want = expected_drives.pop_front();
        check_field("roll_drive", want.roll, roll_drive);
        check_field("pitch_drive", want.pitch, pitch_drive);
        check_field("yaw_drive", want.yaw, yaw_drive);
      end
    end
  end

  initial begin : result_sink
    int held;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
        out_ready <= 1'b0;
        if ($urandom_range(49) == 0) begin
          repeat ($urandom_range(LONG_GAP_MIN, LONG_GAP_MAX)) @(posedge clk);
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : sequencer
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_outer_cadence();
    test_unknown_index();
    test_saturation();
    test_random_settings();
    test_backpressure();
    test_sender_pause();
    test_no_idling();
    await_all_drives();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0 && expected_drives.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
